// ----- hw/rtl/cpb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cpb_pkg;

  // Bus item operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // PPU request codes
  localparam logic [1:0] PPU_REQ_NONE  = 2'd0;
  localparam logic [1:0] PPU_REQ_READ  = 2'd1;
  localparam logic [1:0] PPU_REQ_WRITE = 2'd2;

  // Address map
  localparam logic [15:0] RAM_TOP      = 16'h1FFF;
  localparam logic [15:0] PPU_BASE     = 16'h2000;
  localparam logic [15:0] PPU_TOP      = 16'h3FFF;
  localparam logic [15:0] DMA_TRIGGER  = 16'h4014;
  localparam logic [15:0] PAD0_ADDR    = 16'h4016;
  localparam logic [15:0] PAD1_ADDR    = 16'h4017;

  // Sprite memory size and the tick phase counter period
  localparam int unsigned OAM_BYTES = 256;
  localparam logic [7:0]  OAM_LAST  = 8'(OAM_BYTES - 1);
  localparam logic [2:0]  PHASE_A   = 3'd0;
  localparam logic [2:0]  PHASE_B   = 3'd3;
  localparam logic [2:0]  PHASE_END = 3'd5;

  // Decoded target of one bus access
  typedef enum logic [2:0] {
    REG_NONE = 3'd0,
    REG_CART = 3'd1,
    REG_RAM  = 3'd2,
    REG_PPU  = 3'd3,
    REG_DMA  = 3'd4,
    REG_PAD  = 3'd5
  } region_t;

  // One result item
  typedef struct packed {
    logic [7:0]  read_data;
    logic        cpu_step;
    logic        nmi_out;
    logic [1:0]  ppu_request;
    logic [2:0]  ppu_register;
    logic        ppu_peek;
    logic [7:0]  bus_data_out;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [15:0] dma_source_address;
    logic        dma_active;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cpb_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cpb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        peek_only;
  logic        cart_claims;
  logic [7:0]  cart_data;
  logic [7:0]  ppu_read_data;
  logic [7:0]  pad_buttons_0;
  logic [7:0]  pad_buttons_1;
  logic        ppu_nmi;

  modport source (
    output valid, operation, address, write_data, peek_only, cart_claims,
           cart_data, ppu_read_data, pad_buttons_0, pad_buttons_1, ppu_nmi,
    input  ready
  );

  modport sink (
    input  valid, operation, address, write_data, peek_only, cart_claims,
           cart_data, ppu_read_data, pad_buttons_0, pad_buttons_1, ppu_nmi,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/cpb_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cpb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        cpu_step;
  logic        nmi_out;
  logic [1:0]  ppu_request;
  logic [2:0]  ppu_register;
  logic        ppu_peek;
  logic [7:0]  bus_data_out;
  logic        oam_write;
  logic [7:0]  oam_index;
  logic [15:0] dma_source_address;
  logic        dma_active;

  modport source (
    output valid, read_data, cpu_step, nmi_out, ppu_request, ppu_register,
           ppu_peek, bus_data_out, oam_write, oam_index, dma_source_address,
           dma_active,
    input  ready
  );

  modport sink (
    input  valid, read_data, cpu_step, nmi_out, ppu_request, ppu_register,
           ppu_peek, bus_data_out, oam_write, oam_index, dma_source_address,
           dma_active,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/cpb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cpb_addr_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpb_addr_decode (
  input  wire logic [15:0]     address,
  input  wire logic            cart_claims,
  output cpb_pkg::region_t     region
);
  import cpb_pkg::*;

  // Priority decode: cartridge, RAM, PPU, DMA trigger, controllers
  always_comb begin
    if (cart_claims) begin
      region = REG_CART;
    end else if (address <= RAM_TOP) begin
      region = REG_RAM;
    end else if (address >= PPU_BASE && address <= PPU_TOP) begin
      region = REG_PPU;
    end else if (address == DMA_TRIGGER) begin
      region = REG_DMA;
    end else if (address == PAD0_ADDR || address == PAD1_ADDR) begin
      region = REG_PAD;
    end else begin
      region = REG_NONE;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/console_cpu_bus_with_oam_dma.sv -----
`timescale 1ns / 1ps
`default_nettype none

// CPU bus decoder with sprite DMA.
// in_bus carries one item per handshake: a master clock tick, a CPU write or
// a CPU read, together with the cartridge, PPU, controller and NMI inputs for
// that item. out_bus returns exactly one result item per input item, in order.
// An item that reads work RAM (CPU read, or a DMA read phase that lands in
// RAM) is held in a wait state for the registered read of the RAM; all
// other items push their result at accept. One item per cycle is taken while
// the output queue has room; after a RAM read the next item waits for its data.
// Results sit in a two-entry output queue, so in_bus keeps taking items while
// out_bus is stalled until both entries are full; in_bus.ready then drops.
// Reset (rst_n low, synchronous) clears the phase counter, DMA state,
// controller shift registers and the output queue; work RAM is not cleared
// and holds undefined data until written.
module console_cpu_bus_with_oam_dma #(
  parameter int unsigned RAM_BYTES = 2048
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cpb_in_if.sink    in_bus,
  cpb_out_if.source out_bus
);
  import cpb_pkg::*;

  localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        busy_r, busy_nxt;
  logic        align_r, align_nxt;
  logic [7:0]  page_r, page_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic [7:0]  pad_r [2];
  logic [7:0]  pad_nxt [2];

  result_t     pend_r;
  logic        pend_dma_r;
  result_t     head_r, tail_r;
  logic [1:0]  cnt_r;

  result_t     res;
  result_t     push_data;
  logic        push, pop, acc;
  logic        need_ram, dma_rd, do_read, rd_peek, phase_hit;
  logic [7:0]  rd_val;
  logic [15:0] dec_addr;
  logic        pad_sel;
  region_t     region;
  logic        ram_we;
  logic [7:0]  ram_rdata;

  assign acc          = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE) && (cnt_r != 2'd2);
  assign dec_addr     = (in_bus.operation == OP_TICK) ? {page_r, index_r}
                                                      : in_bus.address;
  assign pad_sel      = dec_addr[0];

  cpb_addr_decode u_dec (
    .address     (dec_addr),
    .cart_claims (in_bus.cart_claims),
    .region      (region)
  );

  cpb_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (dec_addr[RAM_AW-1:0]),
    .wdata (in_bus.write_data),
    .rdata (ram_rdata)
  );

  // Item decode and next state
  always_comb begin
    res        = '0;
    phase_nxt  = phase_r;
    busy_nxt   = busy_r;
    align_nxt  = align_r;
    page_nxt   = page_r;
    index_nxt  = index_r;
    latch_nxt  = latch_r;
    pad_nxt[0] = pad_r[0];
    pad_nxt[1] = pad_r[1];
    ram_we     = 1'b0;
    need_ram   = 1'b0;
    dma_rd     = 1'b0;
    rd_val     = 8'd0;
    phase_hit  = (phase_r == PHASE_A) || (phase_r == PHASE_B);
    rd_peek    = (in_bus.operation == OP_READ) && in_bus.peek_only;

    case (in_bus.operation)
      OP_TICK: begin
        if (phase_hit) begin
          if (busy_r) begin
            if (align_r) begin
              if (phase_r == PHASE_B) begin
                align_nxt = 1'b0;
              end
            end else if (phase_r == PHASE_A) begin
              dma_rd = 1'b1;
            end else begin
              res.bus_data_out = latch_r;
              res.oam_write    = 1'b1;
              res.oam_index    = index_r;
              index_nxt        = index_r + 8'd1;
              if (index_r == OAM_LAST) begin
                index_nxt = 8'd0;
                busy_nxt  = 1'b0;
                align_nxt = 1'b1;
              end
            end
          end else begin
            res.cpu_step = 1'b1;
          end
        end
        res.nmi_out = in_bus.ppu_nmi;
        phase_nxt   = (phase_r == PHASE_END) ? 3'd0 : phase_r + 3'd1;
      end
      OP_WRITE: begin
        case (region)
          REG_RAM: begin
            ram_we = acc;
          end
          REG_PPU: begin
            res.ppu_request  = PPU_REQ_WRITE;
            res.ppu_register = dec_addr[2:0];
            res.bus_data_out = in_bus.write_data;
          end
          REG_DMA: begin
            page_nxt  = in_bus.write_data;
            index_nxt = 8'd0;
            busy_nxt  = 1'b1;
          end
          REG_PAD: begin
            pad_nxt[pad_sel] = pad_sel ? in_bus.pad_buttons_1 : in_bus.pad_buttons_0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Shared read path for CPU reads and DMA read phases
    do_read = (in_bus.operation == OP_READ) || dma_rd;
    if (do_read) begin
      case (region)
        REG_CART: begin
          rd_val = in_bus.cart_data;
        end
        REG_RAM: begin
          need_ram = 1'b1;
        end
        REG_PPU: begin
          res.ppu_request  = PPU_REQ_READ;
          res.ppu_register = dec_addr[2:0];
          res.ppu_peek     = rd_peek;
          rd_val           = in_bus.ppu_read_data;
        end
        REG_PAD: begin
          rd_val           = {7'd0, pad_r[pad_sel][7]};
          pad_nxt[pad_sel] = {pad_r[pad_sel][6:0], 1'b0};
        end
        default: begin
        end
      endcase
      res.read_data = rd_val;
      if (dma_rd) begin
        latch_nxt = rd_val;
      end
    end

    // State reported after the item
    if (!res.oam_write) begin
      res.oam_index = index_nxt;
    end
    res.dma_source_address = {page_nxt, index_nxt};
    res.dma_active         = busy_nxt;

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && need_ram) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result push: at accept, or in the following cycle with RAM data
  always_comb begin
    push_data = res;
    push      = acc && !need_ram;
    if (state_r == S_WAIT) begin
      push_data           = pend_r;
      push_data.read_data = ram_rdata;
      push                = 1'b1;
    end
  end

  assign pop = (cnt_r != 2'd0) && out_bus.ready;

  // Control and DMA state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= 3'd0;
      busy_r   <= 1'b0;
      align_r  <= 1'b1;
      page_r   <= 8'd0;
      index_r  <= 8'd0;
      latch_r  <= 8'd0;
      pad_r[0] <= 8'd0;
      pad_r[1] <= 8'd0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        phase_r  <= phase_nxt;
        busy_r   <= busy_nxt;
        align_r  <= align_nxt;
        page_r   <= page_nxt;
        index_r  <= index_nxt;
        latch_r  <= latch_nxt;
        pad_r[0] <= pad_nxt[0];
        pad_r[1] <= pad_nxt[1];
      end else if (state_r == S_WAIT && pend_dma_r) begin
        latch_r <= ram_rdata;
      end
    end
  end

  // Partial result held across the RAM read
  always_ff @(posedge clk) begin
    if (acc && need_ram) begin
      pend_r     <= res;
      pend_dma_r <= dma_rd;
    end
  end

  // Two-entry output queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b11:   cnt_r <= cnt_r;
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_r <= push_data;
        end else begin
          head_r <= tail_r;
          tail_r <= push_data;
        end
      end
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_r <= push_data;
        end else begin
          tail_r <= push_data;
        end
      end
      2'b01: begin
        head_r <= tail_r;
      end
      default: begin
      end
    endcase
  end

  assign out_bus.valid              = (cnt_r != 2'd0);
  assign out_bus.read_data          = head_r.read_data;
  assign out_bus.cpu_step           = head_r.cpu_step;
  assign out_bus.nmi_out            = head_r.nmi_out;
  assign out_bus.ppu_request        = head_r.ppu_request;
  assign out_bus.ppu_register       = head_r.ppu_register;
  assign out_bus.ppu_peek           = head_r.ppu_peek;
  assign out_bus.bus_data_out       = head_r.bus_data_out;
  assign out_bus.oam_write          = head_r.oam_write;
  assign out_bus.oam_index          = head_r.oam_index;
  assign out_bus.dma_source_address = head_r.dma_source_address;
  assign out_bus.dma_active         = head_r.dma_active;

endmodule

`default_nettype wire

// ----- tb/sv/bus_result_monitor.sv -----
`timescale 1ns / 1ps

// Watches both bus channels, predicts each result item from the accepted
// input items and compares the results in order.
module bus_result_monitor #(
  parameter int unsigned RAM_BYTES = 2048
) (
  input  logic clk,
  input  logic rst_n,
  cpb_in_if    in_bus,
  cpb_out_if   out_bus,
  output int   fail_count,
  output int   pending_count
);
  import cpb_pkg::*;

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the decoder state
  logic [7:0] ram_shadow [RAM_BYTES];
  logic [2:0] tick_phase;
  logic       dma_busy;
  logic       dma_align_wait;
  logic [7:0] dma_src_page;
  logic [7:0] dma_index;
  logic [7:0] dma_latch;
  logic [7:0] pad_shift [2];

  result_t bus_results_due [$];
  int unsigned result_number;

  task automatic clear_state();
    tick_phase     = PHASE_A;
    dma_busy       = 1'b0;
    dma_align_wait = 1'b1;
    dma_src_page   = 8'h00;
    dma_index      = 8'h00;
    dma_latch      = 8'h00;
    pad_shift[0]   = 8'h00;
    pad_shift[1]   = 8'h00;
  endtask

  // Read decode shared by CPU reads and DMA read phases
  task automatic decode_read(input logic [15:0] addr, input logic peek,
                             inout result_t r, output logic [7:0] data);
    if (in_bus.cart_claims) begin
      data = in_bus.cart_data;
    end else if (addr <= RAM_TOP) begin
      data = ram_shadow[addr % RAM_BYTES];
    end else if (addr >= PPU_BASE && addr <= PPU_TOP) begin
      r.ppu_request  = PPU_REQ_READ;
      r.ppu_register = addr[2:0];
      r.ppu_peek     = peek;
      data           = in_bus.ppu_read_data;
    end else if (addr == PAD0_ADDR || addr == PAD1_ADDR) begin
      // controllers shift out MSB first, even on a peek
      data = {7'd0, pad_shift[addr[0]][7]};
      pad_shift[addr[0]] = pad_shift[addr[0]] << 1;
    end else begin
      data = 8'h00;
    end
  endtask

  task automatic compute_bus_result(output result_t r);
    logic [7:0] rd;
    r = '0;
    case (in_bus.operation)
      OP_TICK: begin
        if (tick_phase == PHASE_A || tick_phase == PHASE_B) begin
          if (!dma_busy) begin
            r.cpu_step = 1'b1;
          end else if (dma_align_wait) begin
            if (tick_phase == PHASE_B) dma_align_wait = 1'b0;
          end else if (tick_phase == PHASE_A) begin
            decode_read({dma_src_page, dma_index}, 1'b0, r, rd);
            dma_latch   = rd;
            r.read_data = rd;
          end else begin
            r.bus_data_out = dma_latch;
            r.oam_write    = 1'b1;
            r.oam_index    = dma_index;
            dma_index      = dma_index + 8'd1;
            if (dma_index == 8'd0) begin
              dma_busy       = 1'b0;
              dma_align_wait = 1'b1;
            end
          end
        end
        r.nmi_out  = in_bus.ppu_nmi;
        tick_phase = (tick_phase == PHASE_END) ? PHASE_A : tick_phase + 3'd1;
      end
      OP_WRITE: begin
        if (!in_bus.cart_claims) begin
          if (in_bus.address <= RAM_TOP) begin
            ram_shadow[in_bus.address % RAM_BYTES] = in_bus.write_data;
          end else if (in_bus.address >= PPU_BASE && in_bus.address <= PPU_TOP) begin
            r.ppu_request  = PPU_REQ_WRITE;
            r.ppu_register = in_bus.address[2:0];
            r.bus_data_out = in_bus.write_data;
          end else if (in_bus.address == DMA_TRIGGER) begin
            // a retrigger restarts at index 0 and keeps a pending alignment
            dma_src_page = in_bus.write_data;
            dma_index    = 8'h00;
            dma_busy     = 1'b1;
          end else if (in_bus.address == PAD0_ADDR) begin
            pad_shift[0] = in_bus.pad_buttons_0;
          end else if (in_bus.address == PAD1_ADDR) begin
            pad_shift[1] = in_bus.pad_buttons_1;
          end
        end
      end
      OP_READ: begin
        decode_read(in_bus.address, in_bus.peek_only, r, rd);
        r.read_data = rd;
      end
      default: ;
    endcase
    if (!r.oam_write) r.oam_index = dma_index;
    r.dma_source_address = {dma_src_page, dma_index};
    r.dma_active         = dma_busy;
  endtask

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS)
        $display("result %0d: %s expected 0x%0h, got 0x%0h",
                 result_number, label, want, got);
      fail_count++;
    end
  endtask

  // Predict on input accepts, compare on output accepts
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_state();
      bus_results_due.delete();
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        compute_bus_result(want);
        bus_results_due.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (bus_results_due.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("result %0d: item arrived with no prediction pending", result_number);
          fail_count++;
        end else begin
          want = bus_results_due.pop_front();
          check_field("read_data", want.read_data, out_bus.read_data);
          check_field("cpu_step", want.cpu_step, out_bus.cpu_step);
          check_field("nmi_out", want.nmi_out, out_bus.nmi_out);
          check_field("ppu_request", want.ppu_request, out_bus.ppu_request);
          check_field("ppu_register", want.ppu_register, out_bus.ppu_register);
          check_field("ppu_peek", want.ppu_peek, out_bus.ppu_peek);
          check_field("bus_data_out", want.bus_data_out, out_bus.bus_data_out);
          check_field("oam_write", want.oam_write, out_bus.oam_write);
          check_field("oam_index", want.oam_index, out_bus.oam_index);
          check_field("dma_source_address", want.dma_source_address,
                      out_bus.dma_source_address);
          check_field("dma_active", want.dma_active, out_bus.dma_active);
        end
        result_number++;
      end
    end
    pending_count = bus_results_due.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import cpb_pkg::*;

  localparam int unsigned RAM_SIZE     = 2048;
  localparam logic [1:0]  OP_UNKNOWN   = 2'd3;
  localparam int unsigned ITEM_TARGET  = 1850;
  // ticks that always cover one whole sprite transfer, alignment included
  localparam int unsigned DMA_SPAN     = 1560;
  localparam int unsigned QUIET_TAIL   = 200;
  localparam int unsigned STOP_COUNT   = ITEM_TARGET + QUIET_TAIL;
  localparam int unsigned LONG_HOLD    = 64;
  localparam int unsigned LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        peek;
    logic        claims;
    logic [7:0]  cdata;
    logic [7:0]  pdata;
    logic [7:0]  pad0;
    logic [7:0]  pad1;
    logic        nmi;
  } bus_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;

  cpb_in_if  in_bus ();
  cpb_out_if out_bus ();

  console_cpu_bus_with_oam_dma #(.RAM_BYTES(RAM_SIZE)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  bus_result_monitor #(.RAM_BYTES(RAM_SIZE)) result_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_bus        (in_bus),
    .out_bus       (out_bus),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  // Stimulus bookkeeping: which RAM bytes hold data, and where a DMA may read
  bit          idle_on = 1'b1;
  int unsigned hold_requests;
  int unsigned item_count;
  int unsigned fill_count;
  bit          ram_written [RAM_SIZE];
  int unsigned page_fill [8];
  logic [10:0] ram_index_log [$];
  logic [7:0]  src_page_seen;
  int unsigned ticks_since_trigger = DMA_SPAN;

  function automatic logic [15:0] pick_address(input logic [1:0] op, input bit allow_trigger);
    int unsigned sel;
    logic [15:0] a;
    sel = $urandom_range(0, 9);
    a   = 16'($urandom);
    if (sel < 3) begin
      if (op == OP_READ && ram_index_log.size() > 0)
        a = {3'b000, 2'($urandom), ram_index_log[$urandom_range(0, ram_index_log.size() - 1)]};
      else
        a = {3'b000, a[12:0]};
    end else if (sel < 5) begin
      a = {3'b001, a[12:0]};
    end else if (sel == 5) begin
      a = a[0] ? PAD1_ADDR : PAD0_ADDR;
    end else if (sel == 6 && allow_trigger && op == OP_WRITE) begin
      a = DMA_TRIGGER;
    end
    return a;
  endfunction

  function automatic bus_item_t random_item(input bit allow_trigger);
    bus_item_t it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      it.op = OP_TICK;
    else if (roll < 65) it.op = OP_WRITE;
    else if (roll < 95) it.op = OP_READ;
    else                it.op = OP_UNKNOWN;
    it.addr   = pick_address(it.op, allow_trigger);
    it.wdata  = 8'($urandom);
    it.peek   = 1'($urandom);
    it.claims = ($urandom_range(0, 4) == 0);
    it.cdata  = 8'($urandom);
    it.pdata  = 8'($urandom);
    it.pad0   = 8'($urandom);
    it.pad1   = 8'($urandom);
    it.nmi    = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  function automatic bus_item_t make_item(input logic [1:0] op, input logic [15:0] addr,
                                          input logic [7:0] data);
    bus_item_t it;
    it        = random_item(1'b0);
    it.op     = op;
    it.addr   = addr;
    it.wdata  = data;
    it.peek   = 1'b0;
    it.claims = 1'b0;
    it.nmi    = 1'b0;
    return it;
  endfunction

  function automatic logic [7:0] pick_src_page();
    case ($urandom_range(0, 3))
      0:       return {3'b000, 5'($urandom)};
      1:       return {3'b001, 5'($urandom)};
      2:       return DMA_TRIGGER[15:8];
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one item at a falling edge and hold it until accepted
  task automatic send_item(input bus_item_t it);
    bit dma_risk;
    // never let a CPU read or a DMA read land on RAM that holds no data
    if (it.op == OP_READ && !it.claims && it.addr <= RAM_TOP && !ram_written[it.addr[10:0]])
      it.claims = 1'b1;
    dma_risk = ticks_since_trigger < DMA_SPAN && {src_page_seen, 8'h00} <= RAM_TOP &&
               page_fill[src_page_seen[2:0]] < 256;
    if (it.op == OP_TICK) begin
      if (dma_risk) it.claims = 1'b1;
      if (ticks_since_trigger < DMA_SPAN) ticks_since_trigger++;
    end
    if (it.op == OP_WRITE && !it.claims) begin
      if (it.addr <= RAM_TOP) begin
        if (!ram_written[it.addr[10:0]]) begin
          ram_written[it.addr[10:0]] = 1'b1;
          page_fill[it.addr[10:8]]++;
          ram_index_log.push_back(it.addr[10:0]);
        end
      end else if (it.addr == DMA_TRIGGER) begin
        src_page_seen       = it.wdata;
        ticks_since_trigger = 0;
      end
    end

    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.operation     <= it.op;
    in_bus.address       <= it.addr;
    in_bus.write_data    <= it.wdata;
    in_bus.peek_only     <= it.peek;
    in_bus.cart_claims   <= it.claims;
    in_bus.cart_data     <= it.cdata;
    in_bus.ppu_read_data <= it.pdata;
    in_bus.pad_buttons_0 <= it.pad0;
    in_bus.pad_buttons_1 <= it.pad1;
    in_bus.ppu_nmi       <= it.nmi;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    item_count++;
    @(negedge clk);
  endtask

  // Pause the sender until every predicted result has come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic fill_ram_page(input logic [2:0] page);
    logic [1:0] mirror;
    mirror = 2'($urandom);
    for (int i = 0; i < 256; i++)
      send_item(make_item(OP_WRITE, {3'b000, mirror, page, 8'(i)}, 8'($urandom)));
    fill_count++;
  endtask

  // Trigger a transfer, then mostly ticks with a few CPU accesses and optional retriggers in between
  task automatic run_dma(input logic [7:0] page, input int unsigned n_ticks,
                         input bit retrigger_ok);
    bus_item_t it;
    int unsigned t;
    send_item(make_item(OP_WRITE, DMA_TRIGGER, page));
    t = 0;
    while (t < n_ticks) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(random_item(1'b0));
      end else if (retrigger_ok && $urandom_range(0, 199) == 0) begin
        send_item(make_item(OP_WRITE, DMA_TRIGGER, pick_src_page()));
      end else begin
        it    = random_item(1'b0);
        it.op = OP_TICK;
        send_item(it);
        t++;
      end
    end
  endtask

  task automatic pad_sequence();
    bus_item_t it;
    logic [15:0] a;
    a = $urandom_range(0, 1) ? PAD1_ADDR : PAD0_ADDR;
    send_item(make_item(OP_WRITE, a, 8'($urandom)));
    repeat ($urandom_range(8, 10)) begin
      it      = make_item(OP_READ, a, 8'h00);
      it.peek = 1'($urandom);
      if ($urandom_range(0, 3) == 0) it.op = OP_TICK;
      send_item(it);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_bus.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    bus_item_t   it;
    logic [2:0]  page;
    int unsigned n;
    in_bus.valid         <= 1'b0;
    in_bus.operation     <= OP_TICK;
    in_bus.address       <= 16'h0000;
    in_bus.write_data    <= 8'h00;
    in_bus.peek_only     <= 1'b0;
    in_bus.cart_claims   <= 1'b0;
    in_bus.cart_data     <= 8'h00;
    in_bus.ppu_read_data <= 8'h00;
    in_bus.pad_buttons_0 <= 8'h00;
    in_bus.pad_buttons_1 <= 8'h00;
    in_bus.ppu_nmi       <= 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: map edges, mirrors, peeks, claims, unknown op, pads, DMA
    it     = make_item(OP_TICK, 16'h0000, 8'h00);
    it.nmi = 1'b1;
    send_item(it);
    send_item(make_item(OP_WRITE, 16'h0000, 8'hFF));
    send_item(make_item(OP_WRITE, RAM_TOP, 8'h00));
    send_item(make_item(OP_READ, 16'h0800, 8'h00));
    send_item(make_item(OP_READ, 16'h07FF, 8'h00));
    send_item(make_item(OP_WRITE, PPU_BASE, 8'hA5));
    send_item(make_item(OP_WRITE, PPU_TOP, 8'h5A));
    it       = make_item(OP_READ, 16'h2007, 8'h00);
    it.peek  = 1'b1;
    it.pdata = 8'hFF;
    send_item(it);
    it       = make_item(OP_READ, 16'h3FF8, 8'h00);
    it.pdata = 8'h00;
    send_item(it);
    it        = make_item(OP_READ, 16'h1234, 8'h00);
    it.claims = 1'b1;
    it.cdata  = 8'hC3;
    send_item(it);
    // a claimed trigger write does not start a transfer
    it        = make_item(OP_WRITE, DMA_TRIGGER, 8'h33);
    it.claims = 1'b1;
    send_item(it);
    it        = make_item(OP_UNKNOWN, 16'hFFFF, 8'hFF);
    it.claims = 1'b1;
    it.peek   = 1'b1;
    it.nmi    = 1'b1;
    send_item(it);
    it      = make_item(OP_WRITE, PAD0_ADDR, 8'h00);
    it.pad0 = 8'h81;
    send_item(it);
    it      = make_item(OP_WRITE, PAD1_ADDR, 8'h00);
    it.pad1 = 8'h7E;
    send_item(it);
    it      = make_item(OP_READ, PAD0_ADDR, 8'h00);
    it.peek = 1'b1;
    send_item(it);
    send_item(make_item(OP_READ, PAD1_ADDR, 8'h00));
    send_item(make_item(OP_READ, PAD0_ADDR, 8'h00));
    send_item(make_item(OP_READ, 16'hFFFF, 8'h00));
    send_item(make_item(OP_WRITE, DMA_TRIGGER, PPU_BASE[15:8]));
    repeat (6) send_item(make_item(OP_TICK, 16'h0000, 8'h00));
    send_item(make_item(OP_WRITE, DMA_TRIGGER, DMA_TRIGGER[15:8]));
    repeat (3) send_item(make_item(OP_TICK, 16'h0000, 8'h00));

    // Output back-pressure while the sender keeps offering items
    hold_requests++;
    repeat (40) send_item(random_item(1'b1));
    drain_results();

    // One whole transfer out of a page of RAM that holds data
    page = 3'($urandom);
    fill_ram_page(page);
    run_dma({3'b000, 2'($urandom), page}, DMA_SPAN, 1'b0);

    while (item_count < STOP_COUNT) begin
      if (item_count + QUIET_TAIL > STOP_COUNT) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        3: pad_sequence();
        4, 5: run_dma(pick_src_page(), $urandom_range(20, 300), 1'b1);
        6: begin
          if (fill_count < 3) fill_ram_page(3'($urandom));
          else pad_sequence();
        end
        7: begin
          // noise: any operation, any address
          repeat ($urandom_range(8, 24)) begin
            it        = random_item(1'b1);
            it.op     = 2'($urandom);
            it.addr   = 16'($urandom);
            it.claims = 1'($urandom);
            send_item(it);
          end
        end
        8: begin
          if (idle_on) hold_requests++;
          repeat (24) send_item(random_item(1'b1));
        end
        9: begin
          if (idle_on) drain_results();
          repeat ($urandom_range(8, 32)) send_item(random_item(1'b1));
        end
        default: begin
          n = $urandom_range(8, 32);
          repeat (n) send_item(random_item(1'b1));
        end
      endcase
    end

    // Wait for the last results, then keep the clock running for stray items
    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
